[hw/rtl/mlsn_pkg.sv]
// Package: constants, codes, command/status types and lookup tables for the softmax NLL core.
`default_nettype none
package mlsn_pkg;

  localparam int MAX_PARAMS      = 4;
  localparam int MAX_GROUPS      = 4;
  localparam int EXP_TABLE_DEPTH = 256;
  localparam int EXP_IDX_W       = $clog2(EXP_TABLE_DEPTH);
  localparam int NCOEF           = MAX_PARAMS * (MAX_GROUPS - 1);
  localparam int NCOV            = 4;
  localparam int LOG_DEPTH       = 256;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_PARAMS_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUPS_IN_USE = 2'd1;

  localparam logic [63:0] ONE30 = 64'd1 << 30;

  typedef enum logic [1:0] {
    REQ_COEF  = 2'd0,
    REQ_OBS   = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_type_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_DECODE,
    OP_MAC,
    OP_MAX,
    OP_XDIFF,
    OP_EXP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_STORE,
    OP_NLL,
    OP_ACC,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic       load;
    logic [1:0] grp;
    logic [1:0] prm;
  } dp_cmd_t;

  typedef struct packed {
    req_type_e req;
    logic      out_free;
  } dp_status_t;

  typedef logic [30:0] q30_t;
  typedef q30_t exp_frac_tab_t [EXP_TABLE_DEPTH];
  typedef q30_t exp_int_tab_t [16];
  typedef q30_t ln_tab_t [LOG_DEPTH];

  function automatic logic [63:0] exp_series(input logic [63:0] t);
    logic [63:0] s;
    logic [63:0] term;
    s    = ONE30;
    term = ONE30;
    for (int j = 1; j <= 24; j++) begin
      term = ((term * t) >> 30) / 64'(j);
      if ((j % 2) == 1) s = s - term;
      else s = s + term;
    end
    return s;
  endfunction

  function automatic logic [63:0] two_atanh(input logic [63:0] z);
    logic [63:0] z2;
    logic [63:0] pw;
    logic [63:0] acc;
    z2  = (z * z) >> 30;
    pw  = z;
    acc = 64'd0;
    for (int i = 0; i < 16; i++) begin
      acc = acc + pw / 64'(2 * i + 1);
      pw  = (pw * z2) >> 30;
    end
    return acc * 64'd2;
  endfunction

  function automatic exp_frac_tab_t build_exp_frac();
    exp_frac_tab_t tab;
    for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
      tab[k] = 31'(exp_series((64'(k) << 30) / 64'(EXP_TABLE_DEPTH)));
    end
    return tab;
  endfunction

  function automatic exp_int_tab_t build_exp_int();
    exp_int_tab_t tab;
    logic [63:0]  e1;
    logic [63:0]  v;
    e1 = exp_series(ONE30);
    v  = ONE30;
    tab[0] = 31'(v);
    for (int k = 1; k < 16; k++) begin
      v      = (v * e1) >> 30;
      tab[k] = 31'(v);
    end
    return tab;
  endfunction

  function automatic ln_tab_t build_ln_tab();
    ln_tab_t tab;
    for (int k = 0; k < LOG_DEPTH; k++) begin
      tab[k] = 31'(two_atanh((64'(k) << 30) / 64'(2 * LOG_DEPTH + k)));
    end
    return tab;
  endfunction

  localparam exp_frac_tab_t EXP_FRAC = build_exp_frac();
  localparam exp_int_tab_t  EXP_INT  = build_exp_int();
  localparam ln_tab_t       LN_TAB   = build_ln_tab();
  localparam logic [31:0]   LN_TWO   = 32'(two_atanh(ONE30 / 64'd3));

endpackage
`default_nettype wire

[hw/rtl/mlsn_if.sv]
// Interfaces: request, response and configuration channels of the softmax NLL core.
`default_nettype none
interface mlsn_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [3:0]  coef_index;
  logic [15:0] coef_value;
  logic [15:0] cov_a;
  logic [15:0] cov_b;
  logic [15:0] cov_c;
  logic [15:0] cov_d;
  logic [1:0]  group_label;
  logic        is_prediction;

  modport source (output valid, req_type, coef_index, coef_value, cov_a, cov_b, cov_c,
                  cov_d, group_label, is_prediction, input ready);
  modport sink (input valid, req_type, coef_index, coef_value, cov_a, cov_b, cov_c,
                cov_d, group_label, is_prediction, output ready);
endinterface

interface mlsn_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] prob_a;
  logic [15:0] prob_b;
  logic [15:0] prob_c;
  logic [15:0] prob_d;
  logic [30:0] obs_nll;
  logic [31:0] total_nll;
  logic        nll_saturated;

  modport source (output valid, prob_a, prob_b, prob_c, prob_d, obs_nll, total_nll,
                  nll_saturated, input ready);
  modport sink (input valid, prob_a, prob_b, prob_c, prob_d, obs_nll, total_nll,
                nll_saturated, output ready);
endinterface

interface mlsn_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [2:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hw/rtl/mlsn_ctrl.sv]
// Controller: sequences the datapath through MAC, max, exp, divide and likelihood phases.
`default_nettype none
module mlsn_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  mlsn_pkg::dp_status_t status_i,
  output mlsn_pkg::dp_cmd_t    cmd_o
);
  import mlsn_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_MAC,
    S_MAX,
    S_XDIFF,
    S_EXP,
    S_DIV_INIT,
    S_DIV_STEP,
    S_DIV_STORE,
    S_NLL,
    S_ACC,
    S_EMIT
  } state_e;

  state_e     state_q;
  logic [1:0] grp_q;
  logic [1:0] prm_q;
  logic [3:0] step_q;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o      = '0;
    cmd_o.op   = OP_NONE;
    cmd_o.load = in_valid_i && in_ready_o;
    cmd_o.grp  = grp_q;
    cmd_o.prm  = prm_q;
    unique case (state_q)
      S_IDLE:      cmd_o.op = OP_NONE;
      S_DECODE:    cmd_o.op = OP_DECODE;
      S_MAC:       cmd_o.op = OP_MAC;
      S_MAX:       cmd_o.op = OP_MAX;
      S_XDIFF:     cmd_o.op = OP_XDIFF;
      S_EXP:       cmd_o.op = OP_EXP;
      S_DIV_INIT:  cmd_o.op = OP_DIV_INIT;
      S_DIV_STEP:  cmd_o.op = OP_DIV_STEP;
      S_DIV_STORE: cmd_o.op = OP_DIV_STORE;
      S_NLL:       cmd_o.op = OP_NLL;
      S_ACC:       cmd_o.op = OP_ACC;
      S_EMIT:      cmd_o.op = status_i.out_free ? OP_EMIT : OP_NONE;
      default:     cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      grp_q   <= '0;
      prm_q   <= '0;
      step_q  <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_DECODE;
        end
        S_DECODE: begin
          grp_q <= '0;
          prm_q <= '0;
          state_q <= (status_i.req == REQ_OBS) ? S_MAC : S_IDLE;
        end
        S_MAC: begin
          prm_q <= prm_q + 2'd1;
          if (prm_q == 2'd3) begin
            grp_q <= grp_q + 2'd1;
            if (grp_q == 2'd2) begin
              grp_q   <= '0;
              state_q <= S_MAX;
            end
          end
        end
        S_MAX: begin
          grp_q <= grp_q + 2'd1;
          if (grp_q == 2'd3) state_q <= S_XDIFF;
        end
        S_XDIFF: begin
          grp_q <= grp_q + 2'd1;
          if (grp_q == 2'd3) state_q <= S_EXP;
        end
        S_EXP: begin
          grp_q <= grp_q + 2'd1;
          if (grp_q == 2'd3) state_q <= S_DIV_INIT;
        end
        S_DIV_INIT: begin
          step_q  <= '0;
          state_q <= S_DIV_STEP;
        end
        S_DIV_STEP: begin
          step_q <= step_q + 4'd1;
          if (step_q == 4'd15) state_q <= S_DIV_STORE;
        end
        S_DIV_STORE: begin
          grp_q   <= grp_q + 2'd1;
          state_q <= (grp_q == 2'd3) ? S_NLL : S_DIV_INIT;
        end
        S_NLL:  state_q <= S_ACC;
        S_ACC:  state_q <= S_EMIT;
        S_EMIT: begin
          if (status_i.out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[hw/rtl/mlsn_dp.sv]
// Datapath: coefficient store, shared MAC, exp tables, restoring divider, log and totals.
`default_nettype none
module mlsn_dp (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  mlsn_req_if.sink             req_i,
  mlsn_rsp_if.source           rsp_o,
  mlsn_cfg_if.sink             cfg_i,
  input  mlsn_pkg::dp_cmd_t    cmd_i,
  output mlsn_pkg::dp_status_t status_o
);
  import mlsn_pkg::*;

  logic [2:0] np_cfg_q, ng_cfg_q;
  logic [2:0] np_eff, ng_eff;

  req_type_e          req_q;
  logic [3:0]         coef_idx_q;
  logic [15:0]        coef_val_q;
  logic signed [15:0] cov_q [NCOV];
  logic [1:0]         lab_q;
  logic               pred_q;

  logic signed [15:0] coef_q [NCOEF];
  logic signed [34:0] eta_q [MAX_GROUPS];
  logic signed [34:0] mx_q;
  logic [34:0]        x_q [MAX_GROUPS];
  logic [30:0]        e_q [MAX_GROUPS];
  logic [32:0]        sum_q;
  logic [32:0]        rem_q;
  logic [15:0]        num_q;
  logic [15:0]        quo_q;
  logic [15:0]        prob_q [MAX_GROUPS];
  logic [30:0]        nll_q;
  logic [31:0]        total_q;
  logic               sat_q;
  logic               out_valid_q;

  logic               grp_used, mac_on;
  logic [3:0]         mac_idx;
  logic signed [31:0] mac_prod;
  logic [61:0]        exp_prod;
  logic [30:0]        exp_val;
  logic [45:0]        div_num;
  logic [33:0]        div_trial;
  logic [1:0]         lab_eff;
  logic [1:0]         ln_k;
  logic [7:0]         ln_idx;
  logic [32:0]        ln_sum;
  logic [33:0]        ln_rnd;
  logic [35:0]        nll_full;
  logic [32:0]        tot_sum;

  always_comb begin
    np_eff = (np_cfg_q == 3'd0) ? 3'd1 : np_cfg_q;
    if (np_eff > 3'(MAX_PARAMS)) np_eff = 3'(MAX_PARAMS);
    ng_eff = (ng_cfg_q < 3'd2) ? 3'd2 : ng_cfg_q;
    if (ng_eff > 3'(MAX_GROUPS)) ng_eff = 3'(MAX_GROUPS);
  end

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      np_cfg_q <= 3'd1;
      ng_cfg_q <= 3'd2;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CFG_PARAMS_IN_USE) np_cfg_q <= cfg_i.data;
      else if (cfg_i.index == CFG_GROUPS_IN_USE) ng_cfg_q <= cfg_i.data;
    end
  end

  assign grp_used = {1'b0, cmd_i.grp} < ng_eff;
  assign mac_on   = ({1'b0, cmd_i.grp} < (ng_eff - 3'd1)) && ({1'b0, cmd_i.prm} < np_eff);
  assign mac_idx  = 4'(cmd_i.prm) * 4'(MAX_GROUPS - 1) + 4'(cmd_i.grp);
  assign mac_prod = cov_q[cmd_i.prm] * coef_q[mac_idx];

  assign exp_prod = 62'(EXP_INT[x_q[cmd_i.grp][19:16]])
                  * 62'(EXP_FRAC[x_q[cmd_i.grp][15 -: EXP_IDX_W]]);
  assign exp_val  = (grp_used && (x_q[cmd_i.grp][34:20] == '0)) ? exp_prod[60:30] : '0;

  assign div_num   = {e_q[cmd_i.grp], 15'd0} + 46'(sum_q[32:1]);
  assign div_trial = {rem_q, num_q[15]};

  always_comb begin
    lab_eff = ({1'b0, lab_q} >= ng_eff) ? 2'(ng_eff - 3'd1) : lab_q;
    if (sum_q[32]) begin
      ln_k   = 2'd2;
      ln_idx = sum_q[31:24];
    end else if (sum_q[31]) begin
      ln_k   = 2'd1;
      ln_idx = sum_q[30:23];
    end else begin
      ln_k   = 2'd0;
      ln_idx = sum_q[29:22];
    end
    ln_sum   = 33'(LN_TAB[ln_idx]) + 33'(32'(ln_k) * LN_TWO);
    ln_rnd   = 34'(ln_sum) + 34'd8192;
    nll_full = 36'(x_q[lab_eff]) + 36'(ln_rnd[33:14]);
    tot_sum  = 33'(total_q) + 33'(nll_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q      <= req_type_e'(req_i.req_type);
      coef_idx_q <= req_i.coef_index;
      coef_val_q <= req_i.coef_value;
      cov_q[0]   <= req_i.cov_a;
      cov_q[1]   <= req_i.cov_b;
      cov_q[2]   <= req_i.cov_c;
      cov_q[3]   <= req_i.cov_d;
      lab_q      <= req_i.group_label;
      pred_q     <= req_i.is_prediction;
    end
    unique case (cmd_i.op)
      OP_DECODE: begin
        if (req_q == REQ_COEF && coef_idx_q < 4'(NCOEF)) coef_q[coef_idx_q] <= coef_val_q;
        for (int g = 0; g < MAX_GROUPS; g++) eta_q[g] <= '0;
        mx_q  <= '0;
        sum_q <= '0;
      end
      OP_MAC: begin
        if (mac_on) eta_q[cmd_i.grp] <= eta_q[cmd_i.grp] + 35'(mac_prod);
      end
      OP_MAX: begin
        if (eta_q[cmd_i.grp] > mx_q) mx_q <= eta_q[cmd_i.grp];
      end
      OP_XDIFF: x_q[cmd_i.grp] <= 35'(mx_q - eta_q[cmd_i.grp]);
      OP_EXP: begin
        e_q[cmd_i.grp] <= exp_val;
        sum_q          <= sum_q + 33'(exp_val);
      end
      OP_DIV_INIT: begin
        rem_q <= 33'(div_num[45:16]);
        num_q <= div_num[15:0];
        quo_q <= '0;
      end
      OP_DIV_STEP: begin
        num_q <= {num_q[14:0], 1'b0};
        if (div_trial >= {1'b0, sum_q}) begin
          rem_q <= 33'(div_trial - {1'b0, sum_q});
          quo_q <= {quo_q[14:0], 1'b1};
        end else begin
          rem_q <= 33'(div_trial);
          quo_q <= {quo_q[14:0], 1'b0};
        end
      end
      OP_DIV_STORE: prob_q[cmd_i.grp] <= grp_used ? quo_q : '0;
      OP_NLL: begin
        if (pred_q) nll_q <= '0;
        else if (nll_full > 36'h07FFFFFFF) nll_q <= 31'h7FFFFFFF;
        else nll_q <= 31'(nll_full);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_DECODE && req_q == REQ_CLEAR) begin
        total_q <= '0;
        sat_q   <= 1'b0;
      end else if (cmd_i.op == OP_ACC && !pred_q) begin
        if (tot_sum[32]) begin
          total_q <= '1;
          sat_q   <= 1'b1;
        end else begin
          total_q <= tot_sum[31:0];
        end
      end
      if (cmd_i.op == OP_EMIT) out_valid_q <= 1'b1;
      else if (rsp_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_EMIT) begin
      rsp_o.prob_a        <= prob_q[0];
      rsp_o.prob_b        <= prob_q[1];
      rsp_o.prob_c        <= prob_q[2];
      rsp_o.prob_d        <= prob_q[3];
      rsp_o.obs_nll       <= nll_q;
      rsp_o.total_nll     <= total_q;
      rsp_o.nll_saturated <= sat_q;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign status_o.req      = req_q;
  assign status_o.out_free = !out_valid_q || rsp_o.ready;

endmodule
`default_nettype wire

[hw/rtl/multinomial_logit_softmax_nll_core.sv]
// Top level: softmax class probabilities and running negative log likelihood.
//
// Channels: req_i takes one beat per request (coefficient write, observation, clear);
// rsp_o returns one beat per observation with four Q1.15 probabilities, the Q15.16
// observation NLL, the saturating running total and its sticky saturation flag.
// cfg_i writes params_in_use (index 0) and groups_in_use (index 1); it is always ready.
// The user must write it only while the core is idle; the block does not enforce this.
// Sequence: a coefficient write or clear passes through a single decode state. An
// observation runs the MAC phase on one 16x16 multiplier, then max, difference and
// table exp, then the bit-serial restoring divider for each of the four classes (one
// quotient bit per cycle), then log, accumulate and output load. The divider sets the rate.
// One request is in flight at a time; req_i.ready is high only when the core is idle.
// The result sits in an output register: a new request is accepted while it waits,
// and a finished observation holds in the core until rsp_o has room.
// Reset clears the running total, the flag and the configuration (1 covariate,
// 2 classes); the coefficient table is undefined until written.
`default_nettype none
module multinomial_logit_softmax_nll_core (
  input  wire        clk_i,
  input  wire        rst_ni,
  mlsn_req_if.sink   req_i,
  mlsn_rsp_if.source rsp_o,
  mlsn_cfg_if.sink   cfg_i
);
  import mlsn_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;

  assign req_i.ready = in_ready;

  mlsn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mlsn_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .rsp_o    (rsp_o),
    .cfg_i    (cfg_i),
    .cmd_i    (cmd),
    .status_o (status)
  );

endmodule
`default_nettype wire

[hw/rtl/mlsn_checker.sv]
// Checker: port-level assertions for the softmax NLL core, bound to the top level.
`default_nettype none
module mlsn_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        req_valid,
  input wire        req_ready,
  input wire        rsp_valid,
  input wire        rsp_ready,
  input wire [15:0] prob_a,
  input wire [15:0] prob_b,
  input wire [15:0] prob_c,
  input wire [15:0] prob_d,
  input wire [31:0] total_nll,
  input wire        nll_saturated
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response beat dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while previous one in flight");

  a_prob_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> (prob_a <= 16'h8000) && (prob_b <= 16'h8000) &&
                  (prob_c <= 16'h8000) && (prob_d <= 16'h8000))
    else $error("probability above one");

  a_sat_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && nll_saturated |-> total_nll == 32'hFFFF_FFFF)
    else $error("saturated flag without full-scale total");

endmodule

bind multinomial_logit_softmax_nll_core mlsn_checker u_mlsn_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid     (req_i.valid),
  .req_ready     (req_i.ready),
  .rsp_valid     (rsp_o.valid),
  .rsp_ready     (rsp_o.ready),
  .prob_a        (rsp_o.prob_a),
  .prob_b        (rsp_o.prob_b),
  .prob_c        (rsp_o.prob_c),
  .prob_d        (rsp_o.prob_d),
  .total_nll     (rsp_o.total_nll),
  .nll_saturated (rsp_o.nll_saturated)
);
`default_nettype wire
